// ----- rtl/core/skit_pkg.sv -----
// ----------------------------------------------------------------------------
// skit_pkg: shared types and constants of the sorted key index table
// Capacity, key width, item types and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package skit_pkg;

   localparam int CAPACITY = 256;
   localparam int KEY_BITS = 64;
   localparam int KEY_IN_W = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = CNT_W;
   localparam int ENTRY_W  = IDX_W;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   typedef struct packed {
      logic                command;
      logic [KEY_IN_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [POS_W-1:0]   sorted_position;
      logic [ENTRY_W-1:0] entry_number;
      logic               table_full;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic rd_mid;
      logic rd_lo;
      logic rd_key;
      logic step;
      logic respond;
      logic insert;
      logic shift_rd;
      logic shift_wr;
      logic place;
   } ctl_type;

   typedef struct packed {
      logic searching;
      logic hit;
      logic is_insert;
      logic full;
      logic shift_more;
   } sts_type;

endpackage

// ----- rtl/core/skit_ctrl.sv -----
// ----------------------------------------------------------------------------
// skit_ctrl: sequencing of search, decision and order-list shift
// Drives the datapath through one item: binary search, final check and, for a new key, insert.
// ----------------------------------------------------------------------------
module skit_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  skit_pkg::sts_type sts,
   output skit_pkg::ctl_type ctl
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_RD     = 3'd2;
   localparam logic [2:0] S_CMP    = 3'd3;
   localparam logic [2:0] S_FRD    = 3'd4;
   localparam logic [2:0] S_DECIDE = 3'd5;
   localparam logic [2:0] S_SHIFT  = 3'd6;
   localparam logic [2:0] S_SHWR   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (sts.searching) begin
               ctl.rd_mid = 1'b1;
               state_in   = S_RD;
            end else begin
               ctl.rd_lo = 1'b1;
               state_in  = S_FRD;
            end
         end
         S_RD: begin
            ctl.rd_key = 1'b1;
            state_in   = S_CMP;
         end
         S_CMP: begin
            ctl.step = 1'b1;
            state_in = S_SEARCH;
         end
         S_FRD: begin
            ctl.rd_key = 1'b1;
            state_in   = S_DECIDE;
         end
         S_DECIDE: begin
            ctl.respond = 1'b1;
            if (!sts.hit && sts.is_insert && !sts.full) begin
               ctl.insert = 1'b1;
               state_in   = S_SHIFT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SHIFT: begin
            if (sts.shift_more) begin
               ctl.shift_rd = 1'b1;
               state_in     = S_SHWR;
            end else begin
               ctl.place = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_SHWR: begin
            ctl.shift_wr = 1'b1;
            state_in     = S_SHIFT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/core/skit_dpath.sv -----
// ----------------------------------------------------------------------------
// skit_dpath: key store, order list, search bounds and result register
// Memories have registered reads; each order-list entry moves by a read and then a write.
// ----------------------------------------------------------------------------
module skit_dpath (
   input  logic              clock,
   input  logic              reset,
   input  skit_pkg::req_type req_item,
   input  skit_pkg::ctl_type ctl,
   output skit_pkg::sts_type sts,
   output logic              rsp_valid,
   output skit_pkg::rsp_type rsp_item
);

   logic [skit_pkg::KEY_BITS-1:0] key_mem [skit_pkg::CAPACITY];
   logic [skit_pkg::IDX_W-1:0]    ord_mem [skit_pkg::CAPACITY];

   logic [skit_pkg::KEY_BITS-1:0] key_ff;
   logic                          ins_ff;
   logic [skit_pkg::CNT_W-1:0]    lo_ff;
   logic [skit_pkg::CNT_W-1:0]    hi_ff;
   logic [skit_pkg::CNT_W-1:0]    count_ff;
   logic [skit_pkg::CNT_W-1:0]    idx_ff;
   logic [skit_pkg::IDX_W-1:0]    new_entry_ff;
   logic [skit_pkg::IDX_W-1:0]    ord_q_ff;
   logic [skit_pkg::KEY_BITS-1:0] key_q_ff;
   logic                          rsp_valid_ff;
   skit_pkg::rsp_type             rsp_ff;

   logic [skit_pkg::CNT_W-1:0]    mid;
   logic [skit_pkg::CNT_W-1:0]    idx_m1;
   logic [skit_pkg::IDX_W-1:0]    ord_raddr;
   logic                          ord_rd;
   logic                          ord_we;
   logic [skit_pkg::IDX_W-1:0]    ord_waddr;
   logic [skit_pkg::IDX_W-1:0]    ord_wdata;

   assign mid    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_m1 = idx_ff - skit_pkg::CNT_W'(1);

   assign sts.searching  = (lo_ff < hi_ff);
   assign sts.hit        = (lo_ff < count_ff) && (key_q_ff == key_ff);
   assign sts.is_insert  = (ins_ff == skit_pkg::CMD_INSERT);
   assign sts.full       = (count_ff == skit_pkg::CNT_W'(skit_pkg::CAPACITY));
   assign sts.shift_more = (idx_ff > lo_ff);

   assign ord_rd    = ctl.rd_mid || ctl.rd_lo || ctl.shift_rd;
   assign ord_we    = ctl.shift_wr || ctl.place;
   assign ord_waddr = ctl.place ? lo_ff[skit_pkg::IDX_W-1:0] : idx_ff[skit_pkg::IDX_W-1:0];
   assign ord_wdata = ctl.place ? new_entry_ff : ord_q_ff;

   always_comb begin
      if (ctl.rd_mid) begin
         ord_raddr = mid[skit_pkg::IDX_W-1:0];
      end else if (ctl.rd_lo) begin
         ord_raddr = lo_ff[skit_pkg::IDX_W-1:0];
      end else begin
         ord_raddr = idx_m1[skit_pkg::IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ord_rd) begin
         ord_q_ff <= ord_mem[ord_raddr];
      end
      if (ord_we) begin
         ord_mem[ord_waddr] <= ord_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_key) begin
         key_q_ff <= key_mem[ord_q_ff];
      end
      if (ctl.insert) begin
         key_mem[count_ff[skit_pkg::IDX_W-1:0]] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         key_ff <= req_item.key[skit_pkg::KEY_BITS-1:0];
         ins_ff <= req_item.command;
      end
      if (ctl.load) begin
         lo_ff <= '0;
         hi_ff <= count_ff;
      end else if (ctl.step) begin
         if (key_q_ff < key_ff) begin
            lo_ff <= mid + skit_pkg::CNT_W'(1);
         end else begin
            hi_ff <= mid;
         end
      end
      if (ctl.insert) begin
         idx_ff       <= count_ff;
         new_entry_ff <= count_ff[skit_pkg::IDX_W-1:0];
      end else if (ctl.shift_wr) begin
         idx_ff <= idx_m1;
      end
      if (ctl.respond) begin
         rsp_ff.found           <= sts.hit;
         rsp_ff.sorted_position <= lo_ff;
         rsp_ff.table_full      <= !sts.hit && sts.is_insert && sts.full;
         if (sts.hit) begin
            rsp_ff.entry_number <= ord_q_ff;
         end else if (ctl.insert) begin
            rsp_ff.entry_number <= count_ff[skit_pkg::IDX_W-1:0];
         end else begin
            rsp_ff.entry_number <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.respond;
         if (ctl.insert) begin
            count_ff <= count_ff + skit_pkg::CNT_W'(1);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ----- rtl/core/sorted_key_index_table_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_key_index_table_unit: sorted set of keys with lower-bound search
// An item is taken when start is high and busy is low; its single result
// appears one cycle on rsp_valid/rsp_item and cannot be held off. A lookup is
// a binary search in which each step reads the order list and then the key
// store through their registered read ports. An insert of a new key at sorted
// position p then shifts the order-list entries from p upward after the result,
// each entry moving by a read and then a write of the order list; busy stays
// high until the shift is done. Memories need no clearing after reset.
// ----------------------------------------------------------------------------
module sorted_key_index_table_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  skit_pkg::req_type req_item,
   output logic              rsp_valid,
   output skit_pkg::rsp_type rsp_item
);

   skit_pkg::ctl_type ctl;
   skit_pkg::sts_type sts;

   skit_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   skit_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// ----- rtl/core/skit_checker.sv -----
// ----------------------------------------------------------------------------
// skit_checker: port-level checks of the sorted key index table
// Item acceptance, result strobe timing, refused-insert result contents and found/full exclusion.
// ----------------------------------------------------------------------------
module skit_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input skit_pkg::req_type req_item,
   input logic              rsp_valid,
   input skit_pkg::rsp_type rsp_item
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after item accepted");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result in cycle after acceptance");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.table_full) |->
         (!rsp_item.found && (rsp_item.entry_number == '0)))
      else $error("refused insert reports a match or an entry");

   a_found_not_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.found) |-> !rsp_item.table_full)
      else $error("found and table_full both set");

endmodule

bind sorted_key_index_table_unit skit_checker u_skit_checker (.*);
